// ----- rtl/correlated_poisson_spike_source_macros.svh -----
// Assertion macros used by the checker file cpss_chk.
`ifndef CORRELATED_POISSON_SPIKE_SOURCE_MACROS_SVH
`define CORRELATED_POISSON_SPIKE_SOURCE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CPSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cpss_pkg.sv -----
package cpss_pkg;

  localparam int GROUP_COUNT = 4;
  localparam int GROUP_SIZE  = 16;
  localparam int DELAY_TICKS = 16;
  localparam logic [31:0] TWISTER_SEED = 32'd0;

  localparam int HIST_LEN = DELAY_TICKS * GROUP_COUNT;
  localparam int HIST_AW  = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int GRP_W    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  localparam int IDX_W   = 6;
  localparam int OUT_MAX = 64;
  localparam int CNT_W   = 7;

  localparam int MT_N  = 624;
  localparam int MT_M  = 397;
  localparam int MT_AW = 10;
  localparam logic [31:0] MT_MATRIX   = 32'h9908_b0df;
  localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;

  localparam logic [23:0] LN2_Q24    = 24'd11629080;
  localparam logic [23:0] RATE_RESET = 24'd16777;
  localparam logic [23:0] P_MAX      = 24'hFF_FFFF;

  // ln values stay below 2^29, so do gaps
  localparam int E_W   = 29;
  localparam int POS_W = 30;

  typedef enum logic [2:0] {
    CFG_RATE,
    CFG_MIN_RATE,
    CFG_OU_RATE,
    CFG_NOISE_GAIN,
    CFG_LEVEL_RATE,
    CFG_TARGET,
    CFG_GROUP_OFS,
    CFG_STOP
  } cfg_idx_e;

  typedef struct packed {
    logic        done;
    logic [31:0] word;
  } mt_rsp_t;

  typedef struct packed {
    logic           done;
    logic [E_W-1:0] gap;
  } gap_rsp_t;

  typedef enum logic [2:0] {
    MT_INIT0,
    MT_INITM,
    MT_INITW,
    MT_IDLE,
    MT_RD1,
    MT_RD2,
    MT_RD3
  } mt_state_e;

  typedef enum logic [2:0] {
    GP_IDLE,
    GP_NORM,
    GP_SQM,
    GP_SQA,
    GP_LNM,
    GP_LNA,
    GP_DIV
  } gap_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_LVL,
    ST_LVLA,
    ST_OU,
    ST_OUA,
    ST_GAINA,
    ST_DRAW,
    ST_DWAIT,
    ST_NOISE,
    ST_NOISEA,
    ST_RATE,
    ST_RATEA,
    ST_OFS,
    ST_GRD,
    ST_GRW,
    ST_GDRAW,
    ST_GDWAIT,
    ST_GAP,
    ST_PUSH,
    ST_FLUSH
  } src_state_e;

  function automatic logic [31:0] mt_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- rtl/cpss_ram.sv -----
module cpss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cpss_mt.sv -----
module cpss_mt import cpss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_i,
  output logic    ready_o,
  output mt_rsp_t rsp_o
);

  mt_state_e        state_q, state_d;
  logic [MT_AW-1:0] pos_q, pos_d, idx_q, idx_d;
  logic [31:0]      prev_q, prev_d, prod_q, prod_d;
  logic [31:0]      b_q, b_d, c_q, c_d, word_q, word_d;
  logic             done_q, done_d;

  logic             ram_we;
  logic [MT_AW-1:0] ram_addr;
  logic [31:0]      ram_wdata, ram_rdata;

  logic [MT_AW-1:0] pos_next, pos_far;
  logic [MT_AW:0]   far_sum;
  logic [31:0]      mix, fresh;

  cpss_ram #(.WIDTH(32), .DEPTH(MT_N)) u_words (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Twist lazily: each draw regenerates its own word from i, i+1 and i+M
  assign pos_next = (pos_q == MT_AW'(MT_N - 1)) ? '0 : pos_q + 1'b1;
  assign far_sum  = {1'b0, pos_q} + (MT_AW + 1)'(MT_M);
  assign pos_far  = (far_sum >= (MT_AW + 1)'(MT_N)) ? MT_AW'(far_sum - (MT_AW + 1)'(MT_N))
                                                    : far_sum[MT_AW-1:0];
  assign mix   = {ram_rdata[31], b_q[30:0]};
  assign fresh = c_q ^ (mix >> 1) ^ (mix[0] ? MT_MATRIX : 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MT_INIT0;
      pos_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    prod_q <= prod_d;
    b_q    <= b_d;
    c_q    <= c_d;
    word_q <= word_d;
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    prev_d    = prev_q;
    prod_d    = MT_INIT_MUL * (prev_q ^ (prev_q >> 30));
    b_d       = b_q;
    c_d       = c_q;
    word_d    = word_q;
    ram_we    = 1'b0;
    ram_addr  = pos_q;
    ram_wdata = fresh;
    case (state_q)
      MT_INIT0: begin
        ram_we    = 1'b1;
        ram_addr  = '0;
        ram_wdata = TWISTER_SEED;
        prev_d    = TWISTER_SEED;
        idx_d     = MT_AW'(1);
        state_d   = MT_INITM;
      end
      MT_INITM: begin
        state_d = MT_INITW;
      end
      MT_INITW: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q;
        ram_wdata = prod_q + 32'(idx_q);
        prev_d    = prod_q + 32'(idx_q);
        if (idx_q == MT_AW'(MT_N - 1)) begin
          state_d = MT_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = MT_INITM;
        end
      end
      MT_IDLE: begin
        if (req_i) begin
          ram_addr = pos_next;
          state_d  = MT_RD1;
        end
      end
      MT_RD1: begin
        b_d      = ram_rdata;
        ram_addr = pos_far;
        state_d  = MT_RD2;
      end
      MT_RD2: begin
        c_d      = ram_rdata;
        ram_addr = pos_q;
        state_d  = MT_RD3;
      end
      MT_RD3: begin
        ram_we  = 1'b1;
        word_d  = mt_temper(fresh);
        done_d  = 1'b1;
        pos_d   = pos_next;
        state_d = MT_IDLE;
      end
      default: state_d = MT_IDLE;
    endcase
  end

  assign ready_o   = (state_q == MT_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.word = word_q;

endmodule

// ----- rtl/cpss_gap.sv -----
module cpss_gap import cpss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] word_i,
  input  logic [23:0] prob_i,
  output gap_rsp_t    rsp_o
);

  gap_state_e     state_q, state_d;
  logic [31:0]    y_q, y_d;
  logic [5:0]     k_q, k_d;
  logic [23:0]    frac_q, frac_d, prob_q, prob_d, rem_q, rem_d;
  logic [4:0]     cnt_q, cnt_d, dcnt_q, dcnt_d;
  logic [63:0]    prod_q;
  logic [E_W-1:0] e_q, e_d, quo_q, quo_d;
  logic           done_q, done_d;

  logic [31:0] mul_a, mul_b;
  logic [32:0] m_val, sq;
  logic [29:0] lval;
  logic [24:0] trial;

  assign m_val = 33'h1_0000_0000 - {1'b0, word_i};
  assign sq    = prod_q[63:31];
  assign lval  = {6'd32, 24'd0} - {k_q, frac_q};
  assign trial = {rem_q, e_q[E_W-1]};

  always_comb begin
    if (state_q == GP_LNM) begin
      mul_a = {2'b0, lval};
      mul_b = {8'b0, LN2_Q24};
    end else begin
      mul_a = y_q;
      mul_b = y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GP_IDLE;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dcnt_q  <= dcnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    k_q    <= k_d;
    frac_q <= frac_d;
    prob_q <= prob_d;
    rem_q  <= rem_d;
    e_q    <= e_d;
    quo_q  <= quo_d;
    prod_q <= mul_a * mul_b;
  end

  always_comb begin
    state_d = state_q;
    y_d     = y_q;
    k_d     = k_q;
    frac_d  = frac_q;
    prob_d  = prob_q;
    rem_d   = rem_q;
    e_d     = e_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    dcnt_d  = dcnt_q;
    done_d  = 1'b0;
    case (state_q)
      GP_IDLE: begin
        if (start_i) begin
          prob_d = prob_i;
          frac_d = '0;
          cnt_d  = '0;
          if (m_val[32]) begin
            y_d     = 32'h8000_0000;
            k_d     = 6'd32;
            state_d = GP_SQM;
          end else begin
            y_d     = m_val[31:0];
            k_d     = 6'd31;
            state_d = GP_NORM;
          end
        end
      end
      // Normalize the mantissa to bit 31: a byte at a time, then single bits
      GP_NORM: begin
        if (y_q[31:24] == 8'd0) begin
          y_d = y_q << 8;
          k_d = k_q - 6'd8;
        end else if (!y_q[31]) begin
          y_d = y_q << 1;
          k_d = k_q - 6'd1;
        end else begin
          state_d = GP_SQM;
        end
      end
      GP_SQM: begin
        state_d = GP_SQA;
      end
      // One fraction bit per squaring
      GP_SQA: begin
        frac_d = {frac_q[22:0], sq[32]};
        y_d    = sq[32] ? sq[32:1] : sq[31:0];
        cnt_d  = cnt_q + 1'b1;
        state_d = (cnt_q == 5'd23) ? GP_LNM : GP_SQM;
      end
      GP_LNM: begin
        state_d = GP_LNA;
      end
      GP_LNA: begin
        e_d     = prod_q[24+E_W-1:24];
        rem_d   = '0;
        quo_d   = '0;
        dcnt_d  = '0;
        state_d = GP_DIV;
      end
      // Restoring divide, one quotient bit a cycle
      GP_DIV: begin
        e_d = e_q << 1;
        if (trial >= {1'b0, prob_q}) begin
          rem_d = 24'(trial - {1'b0, prob_q});
          quo_d = {quo_q[E_W-2:0], 1'b1};
        end else begin
          rem_d = trial[23:0];
          quo_d = {quo_q[E_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 5'(E_W - 1)) begin
          done_d  = 1'b1;
          state_d = GP_IDLE;
        end
      end
      default: state_d = GP_IDLE;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.gap  = quo_q;

endmodule

// ----- rtl/correlated_poisson_spike_source.sv -----
// Correlated Poisson spike source. Each accepted item with tick set is one time step:
// the block relaxes an amplitude level toward target_level, steps an Ornstein-Uhlenbeck
// value driven by one Mersenne-twister uniform scaled by that level, and stores
// max(floor, value * rate), capped at P_MAX, as the step's spike probability in a
// circular history of GROUP_COUNT * DELAY_TICKS entries. Each group then reads the
// history delayed by (group + group_offset) * DELAY_TICKS steps and emits neuron
// indices at positions found by summing exponential gaps floor(-ln(1-u)/p) while the
// position stays below GROUP_SIZE; at most 64 items per step, the final one marked by
// last_spike. Ticks past a nonzero stop_tick count but produce nothing. After reset
// the twister memory is seeded one word at a time before the first item is taken.
// Each step runs the level/OU update, then for each group and each emitted spike one
// draw and one gap: a draw makes three reads and a write on the twister memory's
// single port; a gap starts, normalizes, takes the 24 squarings of the log2 on one
// 32x32 multiplier, scales to ln, runs a 29-bit bit-serial divide by p and returns
// the gap. One item is in work at a time.
module correlated_poisson_spike_source import cpss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // tick channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              tick_i,
  // spike channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  neuron_index_o,
  output logic              last_spike_o,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  // Configuration registers
  logic [23:0] rate_q, min_rate_q, ou_rate_q, noise_gain_q, level_rate_q;
  logic [30:0] target_q;
  logic [3:0]  group_ofs_q;
  logic [31:0] stop_q;

  src_state_e state_q, state_d;

  // Tick and OU state
  logic [31:0]        tick_cnt_q, tick_cnt_d;
  logic [HIST_AW-1:0] wpos_q, wpos_d, wsel_q, wsel_d;
  logic [31:0]        level_q, level_d;
  logic signed [31:0] ou_q, ou_d;
  logic signed [35:0] acc_q, acc_d;
  logic [31:0]        gain_q, gain_d, w_q, w_d;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  // Group and spike walk
  logic [HIST_AW-1:0] rd_q, rd_d;
  logic [3:0]         ocnt_q, ocnt_d;
  logic [GRP_W-1:0]   grp_q, grp_d;
  logic [23:0]        prob_q, prob_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [IDX_W-1:0]   new_idx_q, new_idx_d, pend_q, pend_d;
  logic               pend_v_q, pend_v_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [HIST_LEN-1:0] hvalid_q, hvalid_d;
  logic               hv_rd_q, hv_rd_d;

  // Output register
  logic               out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic               out_free;

  // Units
  logic        mt_req, mt_ready, gap_start;
  mt_rsp_t     mt_rsp;
  gap_rsp_t    gap_rsp;
  logic        hist_we;
  logic [HIST_AW-1:0] hist_addr;
  logic [23:0] hist_wdata, hist_rdata;

  // Datapath helpers
  logic               accept, stopped;
  logic signed [35:0] ou_sum, rate_v;
  logic [23:0]        floor_p, clamped;
  logic [POS_W-1:0]   pos_sum;
  logic [IDX_W-1:0]   grp_base;
  logic [HIST_AW-1:0] rd_back;
  logic [HIST_AW:0]   rd_ext;

  cpss_mt u_mt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mt_req),
    .ready_o(mt_ready),
    .rsp_o  (mt_rsp)
  );

  cpss_gap u_gap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gap_start),
    .word_i (mt_rsp.word),
    .prob_i (prob_q),
    .rsp_o  (gap_rsp)
  );

  cpss_ram #(.WIDTH(24), .DEPTH(HIST_LEN)) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .addr_i (hist_addr),
    .wdata_i(hist_wdata),
    .rdata_o(hist_rdata)
  );

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = !((state_q == ST_IDLE) && mt_ready);
  assign accept         = in_valid_i && !in_stall_o;
  assign stopped        = (stop_q != 32'd0) && (tick_cnt_q > stop_q);
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign neuron_index_o = out_idx_q;
  assign last_spike_o   = out_last_q;

  // Step one group further back in the history, wrapping around
  assign rd_ext  = {1'b0, rd_q};
  assign rd_back = (rd_ext >= (HIST_AW + 1)'(DELAY_TICKS))
                 ? HIST_AW'(rd_ext - (HIST_AW + 1)'(DELAY_TICKS))
                 : HIST_AW'(rd_ext + (HIST_AW + 1)'(HIST_LEN - DELAY_TICKS));

  // Saturating OU sum and clamped probability
  assign ou_sum  = acc_q + {prod_q[65], prod_q[65:31]};
  assign rate_v  = prod_q[59:24];
  assign floor_p = (min_rate_q == 24'd0) ? 24'd1 : min_rate_q;
  always_comb begin
    if (rate_v[35]) begin
      clamped = floor_p;
    end else if (rate_v[35:24] != 12'd0) begin
      clamped = P_MAX;
    end else if (rate_v[23:0] < floor_p) begin
      clamped = floor_p;
    end else begin
      clamped = rate_v[23:0];
    end
  end

  assign pos_sum  = pos_q + POS_W'(gap_rsp.gap);
  assign grp_base = IDX_W'(grp_q) * IDX_W'(GROUP_SIZE);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= RATE_RESET;
      min_rate_q   <= 24'd1;
      ou_rate_q    <= 24'd33554;
      noise_gain_q <= 24'd750212;
      level_rate_q <= 24'd28;
      target_q     <= 31'd16777216;
      group_ofs_q  <= 4'd0;
      stop_q       <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RATE:       rate_q       <= cfg_data_i[23:0];
        CFG_MIN_RATE:   min_rate_q   <= cfg_data_i[23:0];
        CFG_OU_RATE:    ou_rate_q    <= cfg_data_i[23:0];
        CFG_NOISE_GAIN: noise_gain_q <= cfg_data_i[23:0];
        CFG_LEVEL_RATE: level_rate_q <= cfg_data_i[23:0];
        CFG_TARGET:     target_q     <= cfg_data_i[30:0];
        CFG_GROUP_OFS:  group_ofs_q  <= cfg_data_i[3:0];
        CFG_STOP:       stop_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_cnt_q  <= '0;
      wpos_q      <= '0;
      level_q     <= 32'h0100_0000;
      ou_q        <= 32'sh0100_0000;
      grp_q       <= '0;
      ocnt_q      <= '0;
      pend_v_q    <= 1'b0;
      n_q         <= '0;
      hvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_cnt_q  <= tick_cnt_d;
      wpos_q      <= wpos_d;
      level_q     <= level_d;
      ou_q        <= ou_d;
      grp_q       <= grp_d;
      ocnt_q      <= ocnt_d;
      pend_v_q    <= pend_v_d;
      n_q         <= n_d;
      hvalid_q    <= hvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_a * mul_b;
    wsel_q    <= wsel_d;
    acc_q     <= acc_d;
    gain_q    <= gain_d;
    w_q       <= w_d;
    rd_q      <= rd_d;
    prob_q    <= prob_d;
    pos_q     <= pos_d;
    new_idx_q <= new_idx_d;
    pend_q    <= pend_d;
    hv_rd_q   <= hv_rd_d;
    out_idx_q <= out_idx_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    state_d     = state_q;
    tick_cnt_d  = tick_cnt_q;
    wpos_d      = wpos_q;
    wsel_d      = wsel_q;
    level_d     = level_q;
    ou_d        = ou_q;
    acc_d       = acc_q;
    gain_d      = gain_q;
    w_d         = w_q;
    rd_d        = rd_q;
    ocnt_d      = ocnt_q;
    grp_d       = grp_q;
    prob_d      = prob_q;
    pos_d       = pos_q;
    new_idx_d   = new_idx_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    n_d         = n_q;
    hvalid_d    = hvalid_q;
    hv_rd_d     = hv_rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    mul_a       = '0;
    mul_b       = '0;
    mt_req      = 1'b0;
    gap_start   = 1'b0;
    hist_we     = 1'b0;
    hist_addr   = rd_q;
    hist_wdata  = clamped;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_START;
          if (tick_i) begin
            tick_cnt_d = tick_cnt_q + 32'd1;
            wsel_d     = wpos_q;
            wpos_d     = (wpos_q == HIST_AW'(HIST_LEN - 1)) ? '0 : wpos_q + 1'b1;
            if (!stopped) begin
              state_d = ST_LVL;
            end
          end
        end
      end
      // Empty or stopped tick: nothing to do
      ST_START: state_d = ST_IDLE;
      // Relax the level toward its target
      ST_LVL: begin
        mul_a   = $signed({2'b0, target_q}) - $signed({1'b0, level_q});
        mul_b   = $signed({9'b0, level_rate_q});
        state_d = ST_LVLA;
      end
      ST_LVLA: begin
        level_d = level_q + prod_q[55:24];
        state_d = ST_OU;
      end
      // Decay term of the OU value
      ST_OU: begin
        mul_a   = 33'sd0 - $signed({ou_q[31], ou_q});
        mul_b   = $signed({9'b0, ou_rate_q});
        state_d = ST_OUA;
      end
      ST_OUA: begin
        acc_d   = {{4{ou_q[31]}}, ou_q} + prod_q[59:24];
        mul_a   = $signed({1'b0, level_q});
        mul_b   = $signed({9'b0, noise_gain_q});
        state_d = ST_GAINA;
      end
      ST_GAINA: begin
        gain_d  = prod_q[55:24];
        state_d = ST_DRAW;
      end
      ST_DRAW: begin
        mt_req  = 1'b1;
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (mt_rsp.done) begin
          w_d     = mt_rsp.word;
          state_d = ST_NOISE;
        end
      end
      // Noise term: centered uniform times level-scaled gain
      ST_NOISE: begin
        mul_a   = $signed({1'b0, w_q}) - 33'sd2147483648;
        mul_b   = $signed({1'b0, gain_q});
        state_d = ST_NOISEA;
      end
      ST_NOISEA: begin
        if (ou_sum[35:31] == 5'b00000 || ou_sum[35:31] == 5'b11111) begin
          ou_d = ou_sum[31:0];
        end else if (ou_sum[35]) begin
          ou_d = 32'sh8000_0000;
        end else begin
          ou_d = 32'sh7fff_ffff;
        end
        state_d = ST_RATE;
      end
      ST_RATE: begin
        mul_a   = $signed({ou_q[31], ou_q});
        mul_b   = $signed({9'b0, rate_q});
        state_d = ST_RATEA;
      end
      // Store this step's probability, then set up the group walk
      ST_RATEA: begin
        hist_we           = 1'b1;
        hist_addr         = wsel_q;
        hvalid_d[wsel_q]  = 1'b1;
        rd_d              = wsel_q;
        ocnt_d            = group_ofs_q;
        grp_d             = '0;
        n_d               = '0;
        pend_v_d          = 1'b0;
        state_d           = ST_OFS;
      end
      ST_OFS: begin
        if (ocnt_q != 4'd0) begin
          rd_d   = rd_back;
          ocnt_d = ocnt_q - 4'd1;
        end else begin
          state_d = ST_GRD;
        end
      end
      ST_GRD: begin
        hv_rd_d = hvalid_q[rd_q];
        state_d = ST_GRW;
      end
      // Entries never written read as the reset rate
      ST_GRW: begin
        prob_d  = hv_rd_q ? hist_rdata : RATE_RESET;
        pos_d   = '0;
        state_d = ST_GDRAW;
      end
      ST_GDRAW: begin
        mt_req  = 1'b1;
        state_d = ST_GDWAIT;
      end
      ST_GDWAIT: begin
        if (mt_rsp.done) begin
          gap_start = 1'b1;
          state_d   = ST_GAP;
        end
      end
      ST_GAP: begin
        if (gap_rsp.done) begin
          if (pos_sum < POS_W'(GROUP_SIZE)) begin
            pos_d     = pos_sum;
            new_idx_d = grp_base + IDX_W'(pos_sum);
            state_d   = ST_PUSH;
          end else if (grp_q == GRP_W'(GROUP_COUNT - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            grp_d   = grp_q + 1'b1;
            rd_d    = rd_back;
            state_d = ST_GRD;
          end
        end
      end
      // Hold each spike back one place so the final one can be marked
      ST_PUSH: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_valid_d = 1'b1;
            out_idx_d   = pend_q;
            out_last_d  = 1'b0;
          end
          pend_d   = new_idx_q;
          pend_v_d = 1'b1;
          n_d      = n_q + 1'b1;
          state_d  = (n_q == CNT_W'(OUT_MAX - 1)) ? ST_FLUSH : ST_GDRAW;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = pend_q;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/cpss_chk.sv -----
`include "correlated_poisson_spike_source_macros.svh"

module cpss_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       tick_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] neuron_index_o,
  input logic       last_spike_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [2:0] cfg_index_i,
  input logic [31:0] cfg_data_i
);

  `CPSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(neuron_index_o) && $stable(last_spike_o), "stalled spike item changed")

  `CPSS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "tick item accepted while busy")

  `CPSS_ASSERT_NEXT(a_quiet_after_last, out_valid_o && !out_stall_i && last_spike_o, !out_valid_o, "spike item after final one of tick")

  `CPSS_ASSERT_NOW(a_idle_only_last, !in_stall_o && out_valid_o, last_spike_o, "non-final spike pending while idle")

endmodule

bind correlated_poisson_spike_source cpss_chk u_cpss_chk (.*);

// ----- verif/cpss_spike_checker.sv -----
`timescale 1ns / 1ps

module cpss_spike_checker import cpss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             tick_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [IDX_W-1:0] neuron_index_i,
  input  logic             last_spike_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  output int               pending_o,
  output int               errors_o
);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } spike_t;

  spike_t expected_spikes[$];

  logic [23:0] rate, min_rate, ou_rate, noise_gain, level_rate;
  logic [30:0] target;
  logic [3:0]  grp_ofs;
  logic [31:0] stop_at;

  logic [31:0]        tick_cnt;
  logic [31:0]        level;
  logic signed [31:0] ou_val;
  logic [23:0]        hist[HIST_LEN];
  logic [31:0]        mt[MT_N];
  int                 mt_pos;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  task automatic reset_model();
    rate       = RATE_RESET;
    min_rate   = 24'd1;
    ou_rate    = 24'd33554;
    noise_gain = 24'd750212;
    level_rate = 24'd28;
    target     = 31'd16777216;
    grp_ofs    = '0;
    stop_at    = '0;
    tick_cnt   = '0;
    level      = 32'd16777216;
    ou_val     = 32'sd16777216;
    for (int i = 0; i < HIST_LEN; i++) hist[i] = RATE_RESET;
    mt[0] = TWISTER_SEED;
    for (int i = 1; i < MT_N; i++)
      mt[i] = MT_INIT_MUL * (mt[i-1] ^ (mt[i-1] >> 30)) + 32'(i);
    mt_pos = MT_N;
    expected_spikes.delete();
  endtask

  function automatic logic [31:0] draw_word();
    logic [31:0] a, y;
    if (mt_pos >= MT_N) begin
      for (int i = 0; i < MT_N; i++) begin
        a = (mt[i] & 32'h8000_0000) | (mt[(i + 1) % MT_N] & 32'h7fff_ffff);
        mt[i] = mt[(i + MT_M) % MT_N] ^ (a >> 1) ^ (a[0] ? MT_MATRIX : 32'd0);
      end
      mt_pos = 0;
    end
    y = mt[mt_pos];
    mt_pos++;
    y ^= y >> 11;
    y ^= (y << 7) & 32'h9d2c_5680;
    y ^= (y << 15) & 32'hefc6_0000;
    y ^= y >> 18;
    return y;
  endfunction

  // log2 in Q8.24 by repeated squaring of the Q1.31 mantissa
  function automatic logic [31:0] log2_fix(input logic [63:0] m);
    int          k;
    logic [23:0] frac;
    logic [63:0] y;
    k = 0;
    frac = '0;
    while (k < 32 && (m >> (k + 1)) != 0) k++;
    y = (k <= 31) ? (m << (31 - k)) : (m >> 1);
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return {8'(k), frac};
  endfunction

  function automatic logic [63:0] gap_len(input logic [23:0] p);
    logic [31:0] w;
    logic [63:0] l, e;
    w = draw_word();
    l = (64'd32 << 24) - 64'(log2_fix(64'h1_0000_0000 - 64'(w)));
    e = (l * 64'(LN2_Q24)) >> 24;
    if (p == 0) p = 24'd1;
    return e / 64'(p);
  endfunction

  task automatic predict_spikes();
    logic [31:0] now, w, gain, floor_p;
    logic [23:0] p;
    longint      v;
    logic [63:0] pos;
    int          n, wpos, back;
    spike_t      burst[$];
    now = tick_cnt;
    tick_cnt = tick_cnt + 1;
    if (stop_at != 0 && now > stop_at) return;
    // relax the level, then step the OU value
    level = 32'(longint'(level) +
            (((longint'(target) - longint'(level)) * longint'(level_rate)) >>> 24));
    w = draw_word();
    gain = 32'((64'(noise_gain) * 64'(level)) >> 24);
    v = longint'(ou_val) + ((-longint'(ou_val) * longint'(ou_rate)) >>> 24)
        + (((longint'(w) - 64'sd2147483648) * longint'(gain)) >>> 31);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    ou_val = 32'(v);
    v = (longint'(ou_val) * longint'(rate)) >>> 24;
    floor_p = (min_rate != 0) ? 32'(min_rate) : 32'd1;
    if (v < longint'(floor_p)) v = longint'(floor_p);
    if (v > longint'(P_MAX)) v = longint'(P_MAX);
    wpos = int'(now % HIST_LEN);
    hist[wpos] = 24'(v);
    n = 0;
    for (int g = 0; g < GROUP_COUNT && n < OUT_MAX; g++) begin
      back = ((g + int'(grp_ofs)) * DELAY_TICKS) % HIST_LEN;
      p = hist[(wpos + HIST_LEN - back) % HIST_LEN];
      pos = gap_len(p);
      while (pos < GROUP_SIZE) begin
        burst.push_back('{idx: IDX_W'(g * GROUP_SIZE + int'(pos)), last: 1'b0});
        n++;
        if (n >= OUT_MAX) break;
        pos += gap_len(p);
      end
    end
    if (n > 0) burst[n-1].last = 1'b1;
    foreach (burst[i]) expected_spikes.push_back(burst[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spike_t want;
    if (!rst_ni) begin
      reset_model();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_RATE:       rate       = cfg_data_i[23:0];
          CFG_MIN_RATE:   min_rate   = cfg_data_i[23:0];
          CFG_OU_RATE:    ou_rate    = cfg_data_i[23:0];
          CFG_NOISE_GAIN: noise_gain = cfg_data_i[23:0];
          CFG_LEVEL_RATE: level_rate = cfg_data_i[23:0];
          CFG_TARGET:     target     = cfg_data_i[30:0];
          CFG_GROUP_OFS:  grp_ofs    = cfg_data_i[3:0];
          CFG_STOP:       stop_at    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i && tick_i) predict_spikes();
      if (out_valid_i && !out_stall_i) begin
        if (expected_spikes.size() == 0) begin
          report("unexpected spike, index", 32'(neuron_index_i), 32'd0);
        end else begin
          want = expected_spikes.pop_front();
          if (neuron_index_i !== want.idx)
            report("neuron_index", 32'(neuron_index_i), 32'(want.idx));
          if (last_spike_i !== want.last)
            report("last_spike", 32'(last_spike_i), 32'(want.last));
        end
      end
    end
    pending_o = expected_spikes.size();
  end

endmodule

// ----- verif/correlated_poisson_spike_source_tb.sv -----
`timescale 1ns / 1ps

module correlated_poisson_spike_source_tb;
  import cpss_pkg::*;

  // generous drain after the last spike: one step with all groups, plus margin
  localparam int DRAIN_CYCLES = 2000;
  localparam int HOLD_CYCLES  = 3000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             tick_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [IDX_W-1:0] neuron_index_o;
  logic             last_spike_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i;
  logic [31:0]      cfg_data_i;

  int          pending, errors;
  logic        steady;     // no idling on either side for this stretch
  logic        hold_req;   // ask the spike side for one long hold-off
  logic [31:0] ticks_done; // accepted items with tick set

  always #4 clk_i = ~clk_i;

  correlated_poisson_spike_source u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .tick_i,
    .out_valid_o, .out_stall_i, .neuron_index_o, .last_spike_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  cpss_spike_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .tick_i,
    .out_valid_i(out_valid_o), .out_stall_i, .neuron_index_i(neuron_index_o),
    .last_spike_i(last_spike_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // Spike side: random stalls, one long hold-off on request.
  initial begin
    int  r, len;
    bit  held;
    logic val;
    held = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        // hold off while the tick side keeps offering items
        held = 1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!steady) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          val = 1'b0;
          len = 0;
        end else if (r < 94) begin
          val = 1'b1;
          len = $urandom_range(0, 2);
        end else begin
          val = 1'b1;
          len = $urandom_range(20, 60);
        end
        out_stall_i <= val;
        repeat (len) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one item; insert a random gap first unless running steady.
  task automatic send_tick(input logic t);
    int r, len;
    len = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 94) len = (r < 75) ? 0 : $urandom_range(1, 3);
      else len = $urandom_range(20, 80);
    end
    if (len > 0) begin
      in_valid_i <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= t;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    if (t) ticks_done++;
  endtask

  // Wait for all spikes, then let an in-flight step with no spikes finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Hold valid across back-to-back writes; end_config drops it.
  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic end_config();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic config_all(input logic [23:0] rt, mn, ou, ng, lr, input logic [30:0] tg,
                            input logic [3:0] ofs, input logic [31:0] stp);
    cfg_write(CFG_RATE, 32'(rt));
    cfg_write(CFG_MIN_RATE, 32'(mn));
    cfg_write(CFG_OU_RATE, 32'(ou));
    cfg_write(CFG_NOISE_GAIN, 32'(ng));
    cfg_write(CFG_LEVEL_RATE, 32'(lr));
    cfg_write(CFG_TARGET, 32'(tg));
    cfg_write(CFG_GROUP_OFS, 32'(ofs));
    cfg_write(CFG_STOP, stp);
    end_config();
  endtask

  initial begin
    logic [31:0] stp;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    tick_i      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_RATE;
    cfg_data_i  <= '0;
    steady      <= 1'b0;
    hold_req    <= 1'b0;
    ticks_done  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, including items with tick clear
    send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
    send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
    drain();

    // rate at full scale with zero floor: p saturates, the spike cap ends each step;
    // a large group offset wraps the history reads
    config_all(24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 24'hFF_FFFF, 31'h7FFF_FFFF,
               4'd15, 32'hFFFF_FFFF);
    repeat (5) send_tick(1'b1);
    drain();

    // full-scale noise gain and OU decay, the level frozen by a zero level rate
    config_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 31'h7FFF_FFFF,
               4'd5, 32'd0);
    repeat (4) send_tick(1'b1);
    drain();

    // stop a couple of steps ahead: later ticks count but stay silent
    config_all(24'h40_0000, 24'd1, 24'd33554, 24'd750212, 24'd28, 31'd16777216,
               4'd0, ticks_done + 2);
    repeat (6) send_tick(1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      stp = ($urandom_range(0, 2) == 0) ? ticks_done + $urandom_range(10, 30) : 32'd0;
      config_all(24'($urandom_range(24'h08_0000, 24'h80_0000)),
                 24'($urandom_range(0, 24'h10_0000)),
                 24'($urandom), 24'($urandom_range(0, 24'h40_0000)),
                 24'($urandom), 31'($urandom_range(0, 32'h0400_0000)),
                 4'($urandom), stp);
      steady <= (ph == 2);
      if (ph == 1) hold_req <= 1'b1;
      for (int i = 0; i < 37; i++) send_tick($urandom_range(0, 9) != 0);
      // pause until every spike of the phase has come
      drain();
      steady <= 1'b0;
    end

    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
